// ===== rtl/dare_pkg.sv =====
package dare_pkg;

    // longest message that is parsed; later bytes only count toward the end
    localparam int MAX_MSG_BYTES = 8192;
    localparam int OFFSET_W      = $clog2(MAX_MSG_BYTES + 1);

    localparam logic [OFFSET_W-1:0] OFS_MAX      = OFFSET_W'(MAX_MSG_BYTES);
    localparam logic [OFFSET_W-1:0] OFS_FLAGS_LO = OFFSET_W'(3);
    localparam logic [OFFSET_W-1:0] OFS_QD_HI    = OFFSET_W'(4);
    localparam logic [OFFSET_W-1:0] OFS_QD_LO    = OFFSET_W'(5);
    localparam logic [OFFSET_W-1:0] OFS_AN_HI    = OFFSET_W'(6);
    localparam logic [OFFSET_W-1:0] OFS_AN_LO    = OFFSET_W'(7);
    localparam logic [OFFSET_W-1:0] OFS_HDR_END  = OFFSET_W'(11);

    localparam logic [7:0] PTR_MASK   = 8'hC0;
    localparam logic [7:0] RCODE_MASK = 8'h0F;

    // bytes left in the fixed answer fields, counted down from ten
    localparam logic [7:0] FIX_LEN     = 8'd10;
    localparam logic [7:0] FIX_TYPE_HI = 8'd10;
    localparam logic [7:0] FIX_TYPE_LO = 8'd9;
    localparam logic [7:0] FIX_RDL_HI  = 8'd2;
    localparam logic [7:0] FIX_RDL_LO  = 8'd1;
    localparam logic [7:0] QTAIL_LEN   = 8'd4;

    localparam logic [15:0] WANTED_TYPE_RST = 16'd16;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_NAME_LEN,
        PH_NAME_PTR,
        PH_NAME_LAB,
        PH_Q_TAIL,
        PH_A_FIX,
        PH_A_MATCH,
        PH_A_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND,
        ST_RCODE,
        ST_NOMATCH,
        ST_TRUNC
    } t_status;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [3:0] rcode;
        logic       last;
    } t_result;

    localparam logic OK_RDATA  = 1'b0;
    localparam logic OK_STATUS = 1'b1;

endpackage

// ===== rtl/dare_msg_if.sv =====
interface dare_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_last;

    modport source (output valid, output msg_byte, output msg_last, input ready);
    modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

// ===== rtl/dare_res_if.sv =====
interface dare_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [3:0] rcode;
    logic       last;

    modport source (output valid, output out_kind, output data_byte, output status,
                    output rcode, output last, input ready);
    modport sink   (input valid, input out_kind, input data_byte, input status,
                    input rcode, input last, output ready);
endinterface

// ===== rtl/dare_cfg_if.sv =====
interface dare_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] wanted_type;

    modport source (output valid, output wanted_type, input ready);
    modport sink   (input valid, input wanted_type, output ready);
endinterface

// ===== rtl/dns_answer_rdata_extractor.sv =====
// DNS response parser that takes one message byte per transfer on i_msg and
// returns, on o_res, the RDATA bytes of the first answer whose TYPE equals the
// configured wanted_type (reset 16), followed on the byte flagged msg_last by
// one status item: found, RCODE error (with the RCODE), no matching answer, or
// truncated/malformed. The parser then rearms for the next message. A byte is
// accepted every clock cycle while i_msg.ready is high; each byte is parsed
// combinationally by the header/name/answer state machine and yields at most
// two result items, which go into a four-entry result queue. i_msg.ready is
// low only while that queue has fewer than two free slots, so throughput is
// one byte per cycle as long as the sink takes one result per cycle. Bytes
// beyond MAX_MSG_BYTES are ignored except for msg_last. wanted_type must be
// written through i_cfg only while the block is idle; the block does not enforce this.
module dns_answer_rdata_extractor
    import dare_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dare_msg_if.sink  i_msg,
    dare_cfg_if.sink  i_cfg,
    dare_res_if.source o_res
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // parser state
    t_phase              r_phase,    n_phase;
    logic [OFFSET_W-1:0] r_offset,   n_offset;
    logic [7:0]          r_skip,     n_skip;
    logic [15:0]         r_qleft,    n_qleft;
    logic [15:0]         r_aleft,    n_aleft;
    logic [15:0]         r_atype,    n_atype;
    logic [15:0]         r_rdata,    n_rdata;
    t_status             r_status,   n_status;
    logic [3:0]          r_rcode,    n_rcode;
    logic [15:0]         r_wanted_type;

    // result queue
    t_result             r_fifo [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic        msg_xfer;
    logic        res_xfer;
    logic        emit;
    logic [7:0]  skip_dec;
    logic [15:0] q_dec;
    logic [15:0] a_dec;
    logic [15:0] rd_dec;
    logic [15:0] rd_fix;
    logic [1:0]  push_cnt;
    t_result     first_item;
    t_result     status_item;

    // room for two results guarantees a byte can always be taken
    assign i_msg.ready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign i_cfg.ready = 1'b1;
    assign msg_xfer    = i_msg.valid & i_msg.ready;
    assign res_xfer    = o_res.valid & o_res.ready;

    assign skip_dec = r_skip - 8'd1;
    assign q_dec    = r_qleft - 16'd1;
    assign a_dec    = r_aleft - 16'd1;
    assign rd_dec   = r_rdata - 16'd1;
    assign rd_fix   = {r_rdata[15:8], i_msg.msg_byte};

    // next-state logic for one byte
    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_skip   = r_skip;
        n_qleft  = r_qleft;
        n_aleft  = r_aleft;
        n_atype  = r_atype;
        n_rdata  = r_rdata;
        n_status = r_status;
        n_rcode  = r_rcode;
        emit     = 1'b0;

        if (r_offset < OFS_MAX) begin
            n_offset = r_offset + OFFSET_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_offset == OFS_FLAGS_LO) begin
                        n_rcode = 4'(i_msg.msg_byte & RCODE_MASK);
                        if (n_rcode != 4'd0) begin
                            n_status = ST_RCODE;
                            n_phase  = PH_DONE;
                        end
                    end else if (r_offset == OFS_QD_HI) begin
                        n_qleft = {i_msg.msg_byte, 8'h00};
                    end else if (r_offset == OFS_QD_LO) begin
                        n_qleft = {r_qleft[15:8], i_msg.msg_byte};
                    end else if (r_offset == OFS_AN_HI) begin
                        n_aleft = {i_msg.msg_byte, 8'h00};
                    end else if (r_offset == OFS_AN_LO) begin
                        n_aleft = {r_aleft[15:8], i_msg.msg_byte};
                    end else if (r_offset == OFS_HDR_END) begin
                        if (r_qleft != 16'd0 || r_aleft != 16'd0) begin
                            n_phase = PH_NAME_LEN;
                        end else begin
                            n_status = ST_NOMATCH;
                            n_phase  = PH_DONE;
                        end
                    end
                end
                PH_NAME_LEN, PH_NAME_PTR: begin
                    if (r_phase == PH_NAME_LEN && i_msg.msg_byte != 8'd0) begin
                        // compression pointer or plain label length
                        if ((i_msg.msg_byte & PTR_MASK) == PTR_MASK) begin
                            n_phase = PH_NAME_PTR;
                        end else begin
                            n_skip  = i_msg.msg_byte;
                            n_phase = PH_NAME_LAB;
                        end
                    end else if (r_qleft != 16'd0) begin
                        n_skip  = QTAIL_LEN;
                        n_phase = PH_Q_TAIL;
                    end else begin
                        n_skip  = FIX_LEN;
                        n_phase = PH_A_FIX;
                    end
                end
                PH_NAME_LAB: begin
                    n_skip = skip_dec;
                    if (skip_dec == 8'd0) begin
                        n_phase = PH_NAME_LEN;
                    end
                end
                PH_Q_TAIL: begin
                    n_skip = skip_dec;
                    if (skip_dec == 8'd0) begin
                        n_qleft = q_dec;
                        if (q_dec != 16'd0 || r_aleft != 16'd0) begin
                            n_phase = PH_NAME_LEN;
                        end else begin
                            n_status = ST_NOMATCH;
                            n_phase  = PH_DONE;
                        end
                    end
                end
                PH_A_FIX: begin
                    n_skip = skip_dec;
                    if (r_skip == FIX_TYPE_HI) begin
                        n_atype = {i_msg.msg_byte, 8'h00};
                    end else if (r_skip == FIX_TYPE_LO) begin
                        n_atype = {r_atype[15:8], i_msg.msg_byte};
                    end else if (r_skip == FIX_RDL_HI) begin
                        n_rdata = {i_msg.msg_byte, 8'h00};
                    end else if (r_skip == FIX_RDL_LO) begin
                        n_rdata = rd_fix;
                        if (r_atype == r_wanted_type) begin
                            if (rd_fix == 16'd0) begin
                                n_status = ST_FOUND;
                                n_phase  = PH_DONE;
                            end else begin
                                n_phase = PH_A_MATCH;
                            end
                        end else if (rd_fix != 16'd0) begin
                            n_phase = PH_A_SKIP;
                        end else begin
                            n_aleft = a_dec;
                            if (a_dec == 16'd0) begin
                                n_status = ST_NOMATCH;
                                n_phase  = PH_DONE;
                            end else begin
                                n_phase = PH_NAME_LEN;
                            end
                        end
                    end
                end
                PH_A_MATCH: begin
                    emit    = 1'b1;
                    n_rdata = rd_dec;
                    if (rd_dec == 16'd0) begin
                        n_status = ST_FOUND;
                        n_phase  = PH_DONE;
                    end
                end
                PH_A_SKIP: begin
                    n_rdata = rd_dec;
                    if (rd_dec == 16'd0) begin
                        n_aleft = a_dec;
                        if (a_dec == 16'd0) begin
                            n_status = ST_NOMATCH;
                            n_phase  = PH_DONE;
                        end else begin
                            n_phase = PH_NAME_LEN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // status item reflects this byte's update, then the parser rearms
        status_item.out_kind  = OK_STATUS;
        status_item.data_byte = 8'd0;
        status_item.status    = n_status;
        status_item.rcode     = n_rcode;
        status_item.last      = 1'b1;

        if (i_msg.msg_last) begin
            n_phase  = PH_HEADER;
            n_offset = '0;
            n_skip   = 8'd0;
            n_qleft  = 16'd0;
            n_aleft  = 16'd0;
            n_atype  = 16'd0;
            n_rdata  = 16'd0;
            n_status = ST_TRUNC;
            n_rcode  = 4'd0;
        end
    end

    // rdata item goes first when a byte yields both
    always_comb begin
        first_item = status_item;
        if (emit) begin
            first_item.out_kind  = OK_RDATA;
            first_item.data_byte = i_msg.msg_byte;
            first_item.status    = 2'd0;
            first_item.rcode     = 4'd0;
            first_item.last      = 1'b0;
        end
        push_cnt = msg_xfer ? (2'(emit) + 2'(i_msg.msg_last)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_offset      <= '0;
            r_skip        <= 8'd0;
            r_qleft       <= 16'd0;
            r_aleft       <= 16'd0;
            r_atype       <= 16'd0;
            r_rdata       <= 16'd0;
            r_status      <= ST_TRUNC;
            r_rcode       <= 4'd0;
            r_wanted_type <= WANTED_TYPE_RST;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (msg_xfer) begin
                r_phase  <= n_phase;
                r_offset <= n_offset;
                r_skip   <= n_skip;
                r_qleft  <= n_qleft;
                r_aleft  <= n_aleft;
                r_atype  <= n_atype;
                r_rdata  <= n_rdata;
                r_status <= n_status;
                r_rcode  <= n_rcode;
            end
            if (i_cfg.valid) begin
                r_wanted_type <= i_cfg.wanted_type;
            end
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(res_xfer);
            r_count  <= r_count + QCNT_W'(push_cnt) - QCNT_W'(res_xfer);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_item;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + QPTR_W'(1)] <= status_item;
        end
    end

    assign o_res.valid     = (r_count != '0);
    assign o_res.out_kind  = r_fifo[r_rd_ptr].out_kind;
    assign o_res.data_byte = r_fifo[r_rd_ptr].data_byte;
    assign o_res.status    = r_fifo[r_rd_ptr].status;
    assign o_res.rcode     = r_fifo[r_rd_ptr].rcode;
    assign o_res.last      = r_fifo[r_rd_ptr].last;

endmodule
